// ===== rtl/hri_pkg.sv =====
// shared types and constants of the halton radical inverse unit
// no dependencies

package hri_pkg;

    localparam int BASE_W  = 5;
    localparam int DIGIT_W = 4;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

    // token and carry handed from one digit cell to the next
    typedef struct packed {
        logic en;
        logic carry;
    } hri_link_t;

endpackage

// ===== rtl/hri_cell.sv =====
// one radix digit cell: doubles its digit with carry in, modulo the base
// depends on hri_pkg

module hri_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic [hri_pkg::BASE_W-1:0] base,
    input  hri_pkg::hri_link_t        up_in,
    input  hri_pkg::hri_link_t        down_in,
    output hri_pkg::hri_link_t        up_out,
    output hri_pkg::hri_link_t        down_out
);
    import hri_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    hri_link_t          up_reg;
    hri_link_t          up_next;
    hri_link_t          down_reg;
    hri_link_t          down_next;
    logic               active;
    logic               carry_in;
    logic [DIGIT_W:0]   sum;
    logic [DIGIT_W:0]   diff;
    logic               wrap;

    always_comb
    begin
        active   = up_in.en | down_in.en;
        carry_in = up_in.en ? up_in.carry : down_in.carry;
        sum      = {digit_reg, 1'b0} + {{DIGIT_W{1'b0}}, carry_in};
        diff     = sum - base;
        wrap     = (sum >= base);
        digit_next = digit_reg;
        if (clear)
        begin
            digit_next = '0;
        end
        else if (active)
        begin
            digit_next = wrap ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
        end
        up_next.en      = up_in.en;
        up_next.carry   = up_in.en & wrap;
        down_next.en    = down_in.en;
        down_next.carry = down_in.en & wrap;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= '0;
            down_reg <= '0;
        end
        else
        begin
            up_reg   <= up_next;
            down_reg <= down_next;
        end
    end

    assign up_out   = up_reg;
    assign down_out = down_reg;

endmodule

// ===== rtl/halton_radical_inverse_unit.sv =====
// the index passes twice through the skewed digit chain of INDEX_BITS cells:
// binary to radix digits, then radix fraction to binary bits
// flow: a new index is taken only in idle, once the previous result has moved to the
// output register; while out_valid is held with out_ready low, a finished result waits
// reset: async active-low rst_n returns the controller to idle, no output pending
// depends on hri_pkg and hri_cell

module halton_radical_inverse_unit #(
    parameter int INDEX_BITS    = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [INDEX_BITS-1:0]     index,
    input  logic [hri_pkg::BASE_W-1:0] base,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [FRACTION_BITS-1:0]  fraction_q24
);
    import hri_pkg::*;

    localparam int NCELL   = INDEX_BITS;
    localparam int BIN_END = INDEX_BITS + NCELL - 1;
    localparam int FRC_END = FRACTION_BITS + NCELL - 1;
    localparam int CNT_MAX = (BIN_END > FRC_END) ? BIN_END : FRC_END;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_BIN  = 4'b0010,
        S_FRAC = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [INDEX_BITS-1:0]    idx_reg;
    logic [INDEX_BITS-1:0]    idx_next;
    logic [BASE_W-1:0]        base_reg;
    logic [BASE_W-1:0]        base_next;
    logic                     bad_reg;
    logic                     bad_next;
    logic [FRACTION_BITS-1:0] frac_reg;
    logic [FRACTION_BITS-1:0] frac_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [FRACTION_BITS-1:0] out_data_reg;
    logic [FRACTION_BITS-1:0] out_data_next;
    logic                     out_free;
    logic                     take;
    hri_link_t                up_feed;
    hri_link_t                down_feed;
    hri_link_t                up_link   [NCELL];
    hri_link_t                down_link [NCELL];

    assign take     = in_valid & in_ready;
    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        up_feed.en      = (state_reg == S_BIN) && (cnt_reg < CNT_W'(INDEX_BITS));
        up_feed.carry   = idx_reg[INDEX_BITS-1];
        down_feed.en    = (state_reg == S_FRAC) && (cnt_reg < CNT_W'(FRACTION_BITS));
        down_feed.carry = 1'b0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            hri_link_t up_src;
            hri_link_t down_src;
            if (gi == 0)
            begin : g_first
                assign up_src = up_feed;
            end
            else
            begin : g_rest
                assign up_src = up_link[gi-1];
            end
            if (gi == NCELL - 1)
            begin : g_last
                assign down_src = down_feed;
            end
            else
            begin : g_inner
                assign down_src = down_link[gi+1];
            end
            hri_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .clear    (take),
                .base     (base_reg),
                .up_in    (up_src),
                .down_in  (down_src),
                .up_out   (up_link[gi]),
                .down_out (down_link[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        bad_next       = bad_reg;
        frac_next      = frac_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    idx_next   = index;
                    base_next  = base;
                    bad_next   = (base < BASE_MIN) || (base > BASE_MAX);
                    cnt_next   = '0;
                    state_next = S_BIN;
                end
            end
            S_BIN:
            begin
                if (up_feed.en)
                begin
                    idx_next = {idx_reg[INDEX_BITS-2:0], 1'b0};
                end
                if (up_link[NCELL-1].en && (cnt_reg == CNT_W'(BIN_END)))
                begin
                    cnt_next   = '0;
                    state_next = S_FRAC;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FRAC:
            begin
                if (down_link[0].en)
                begin
                    frac_next = {frac_reg[FRACTION_BITS-2:0], down_link[0].carry & ~bad_reg};
                end
                if (down_link[0].en && (cnt_reg == CNT_W'(FRC_END)))
                begin
                    cnt_next = '0;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = frac_next;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = frac_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        base_reg     <= base_next;
        bad_reg      <= bad_next;
        frac_reg     <= frac_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign fraction_q24 = out_data_reg;

endmodule
